[rtl/isl_pkg.sv]
package isl_pkg;

	// List geometry.
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Fixed field widths.
	localparam int CMD_W  = 3;
	localparam int POS_W  = 5;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;
	localparam int ECNT_W = 5;

	// Width used to compare a position against the count.
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_GET     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PREPEND = 3'd4;
	localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd5;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_NULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_OOB  = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

	// Cell operations broadcast along the row.
	localparam logic [1:0] OP_HOLD     = 2'd0;
	localparam logic [1:0] OP_WRITE    = 2'd1;
	localparam logic [1:0] OP_SHIFT_UP = 2'd2;
	localparam logic [1:0] OP_SHIFT_DN = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [IDX_W-1:0]  pos;
		logic [WORD_W-1:0] word;
	} cell_ctl_t;

endpackage

[rtl/isl_cell.sv]
module isl_cell (
	input  logic                       clk,
	input  isl_pkg::cell_ctl_t         ctl,
	input  logic [isl_pkg::IDX_W-1:0]  idx,
	input  logic [isl_pkg::WORD_W-1:0] left_val,
	input  logic [isl_pkg::WORD_W-1:0] right_val,
	output logic [isl_pkg::WORD_W-1:0] val
);
	import isl_pkg::*;

	logic [WORD_W-1:0] val_q;
	logic [WORD_W-1:0] val_d;

	// Choose the next word from own position relative to the target.
	always_comb begin
		val_d = val_q;
		case (ctl.op)
			OP_WRITE: begin
				if (idx == ctl.pos) val_d = ctl.word;
			end
			OP_SHIFT_UP: begin
				if (idx == ctl.pos) val_d = ctl.word;
				else if (idx > ctl.pos) val_d = left_val;
			end
			OP_SHIFT_DN: begin
				if (idx >= ctl.pos) val_d = right_val;
			end
			default: begin
				val_d = val_q;
			end
		endcase
	end

	// Stored word; contents are undefined until written.
	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val = val_q;

endmodule

[rtl/indexed_shift_list_unit.sv]
// Indexed shift list: an ordered list of up to DEPTH 32-bit words.
// Input channel: a command beat (cmd, position, item_word) is taken at a
// rising edge where start is high and busy is low. Commands are get,
// replace, insert, delete, prepend and append.
// Result channel: exactly one result beat per command. done is high for
// one cycle, the cycle after the command is taken, with status, read_word
// and entry_count valid in that cycle. The receiver cannot stall; each
// result must be taken in the cycle it is shown.
// Throughput: one command per cycle while busy is low. Every cell of the
// row compares its own index with the target and, at the same edge,
// writes, shifts from a neighbor or holds, so an insert or delete
// costs the same as a get.
// Reset: arst_n clears the count, so the list is empty. busy is high while
// in reset and is cleared by the first clock edge after it. The words
// themselves are not cleared; only positions below the count are ever read.
module indexed_shift_list_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [isl_pkg::CMD_W-1:0]  cmd,
	input  logic [isl_pkg::POS_W-1:0]  position,
	input  logic [isl_pkg::WORD_W-1:0] item_word,
	output logic                       done,
	output logic [isl_pkg::STAT_W-1:0] status,
	output logic [isl_pkg::WORD_W-1:0] read_word,
	output logic [isl_pkg::ECNT_W-1:0] entry_count
);
	import isl_pkg::*;

	logic                busy_q;
	logic [CNT_W-1:0]    count_q;
	logic                done_q;
	logic [STAT_W-1:0]   status_q;
	logic [WORD_W-1:0]   read_word_q;
	logic [ECNT_W-1:0]   entry_count_q;

	logic                accept;
	logic [CMP_W-1:0]    pos_c;
	logic [CMP_W-1:0]    cnt_c;
	logic                is_null;
	logic                is_full;
	logic [CMP_W-1:0]    put_pos;
	logic [STAT_W-1:0]   stat_d;
	logic [WORD_W-1:0]   rd_d;
	logic [CNT_W-1:0]    count_d;
	logic [WORD_W-1:0]   sel_val;
	cell_ctl_t           ctl;

	logic [WORD_W-1:0]   cell_val [DEPTH];

	assign accept  = start && !busy_q;
	assign pos_c   = CMP_W'(position);
	assign cnt_c   = CMP_W'(count_q);
	assign is_null = (item_word == '0);
	assign is_full = (count_q == CNT_W'(DEPTH));
	assign sel_val = cell_val[position[IDX_W-1:0]];

	// Target position for the insert family.
	always_comb begin
		case (cmd)
			CMD_PREPEND: put_pos = '0;
			CMD_APPEND:  put_pos = cnt_c;
			default:     put_pos = pos_c;
		endcase
	end

	// Command decode: status, read word, next count and the row operation.
	always_comb begin
		stat_d   = ST_OK;
		rd_d     = '0;
		count_d  = count_q;
		ctl.op   = OP_HOLD;
		ctl.pos  = position[IDX_W-1:0];
		ctl.word = item_word;
		case (cmd)
			CMD_GET: begin
				if (pos_c >= cnt_c) stat_d = ST_OOB;
				else rd_d = sel_val;
			end
			CMD_REPLACE: begin
				if (is_null) stat_d = ST_NULL;
				else if (pos_c >= cnt_c) stat_d = ST_OOB;
				else ctl.op = OP_WRITE;
			end
			CMD_DELETE: begin
				if (pos_c >= cnt_c) begin
					stat_d = ST_OOB;
				end else begin
					rd_d    = sel_val;
					ctl.op  = OP_SHIFT_DN;
					count_d = count_q - 1'b1;
				end
			end
			CMD_INSERT, CMD_PREPEND, CMD_APPEND: begin
				ctl.pos = put_pos[IDX_W-1:0];
				if (is_null) stat_d = ST_NULL;
				else if (put_pos > cnt_c) stat_d = ST_OOB;
				else if (is_full) stat_d = ST_FULL;
				else begin
					ctl.op  = OP_SHIFT_UP;
					count_d = count_q + 1'b1;
				end
			end
			default: begin
				stat_d = ST_OK;
			end
		endcase
		if (!accept) ctl.op = OP_HOLD;
	end

	// Row of storage cells, each linked to both neighbors.
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;

		if (gi == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_val[gi-1];
		end

		if (gi == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_val[gi+1];
		end

		isl_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (IDX_W'(gi)),
			.left_val  (left_w),
			.right_val (right_w),
			.val       (cell_val[gi])
		);
	end

	// Control state: busy flag, entry count and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			done_q <= accept;
			if (accept) count_q <= count_d;
		end
	end

	// Result beat payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= stat_d;
			read_word_q   <= rd_d;
			entry_count_q <= ECNT_W'(count_d);
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign status      = status_q;
	assign read_word   = read_word_q;
	assign entry_count = entry_count_q;

endmodule
